// File: src/bitmap_frame_allocator_defines.svh
// ----------------------------------------------------------------------------
// bitmap frame allocator assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, reset by rst_ni
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// plain property check
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition implies something on the next edge
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFA_ASSERT(lbl, prop, msg)
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// constants and types of the bitmap frame allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int FRAME_TOTAL   = 65536;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS     = (FRAME_TOTAL + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int ADDR_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OFF_W         = $clog2(MAP_WORD_BITS);

  localparam int OP_W    = 2;
  localparam int FRAME_W = 16;
  localparam int COUNT_W = 17;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 1;

  // frame pointers hold range_start plus a full count, and any map frame
  localparam int PTR_W = ($clog2(FRAME_TOTAL) + 1 > COUNT_W + 1) ?
                         $clog2(FRAME_TOTAL) + 1 : COUNT_W + 1;

  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_START = 1'd0,
    CFG_RANGE_LIMIT = 1'd1
  } cfg_idx_e;

endpackage

// File: src/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: src/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// first-fit page frame allocator over a used bitmap held in one ram
// ----------------------------------------------------------------------------
// usage:
//   a request (operation, first_frame, frame_count) is taken on a clock edge
//   with start_i high and busy_o low. allocate searches from range_start for
//   num free frames in a row, free clears a run, mark sets a run.
//   each request gives one result: done_o is high for exactly one cycle with
//   granted_frame_o and status_o; the receiver cannot stall it.
//   the map sits in a 1024 x 64 ram. a search step reads one word and
//   evaluates it on the next cycle; each word visited, and each used
//   frame that restarts the run, takes one such step. a run write then
//   reads each word touched and writes it back modified, then ends with a
//   final check. free and mark use the same run write.
//   the range registers are written through cfg_valid_i / cfg_ready_o, by
//   the user only while the block is idle; the block does not enforce it.
//   after reset a clearing pass zeroes all 1024 words of the ram, one word
//   a cycle, with busy_o high; config writes are taken throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_frame_allocator_defines.svh"

module bitmap_frame_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [bfa_pkg::OP_W-1:0]      operation_i,
  input  logic [bfa_pkg::FRAME_W-1:0]   first_frame_i,
  input  logic [bfa_pkg::COUNT_W-1:0]   frame_count_i,
  output logic                          done_o,
  output logic [bfa_pkg::FRAME_W-1:0]   granted_frame_o,
  output logic                          status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bfa_pkg::CFG_W-1:0]     cfg_data_i
);
  import bfa_pkg::*;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_SRD  = 6'b000100,
    S_SEV  = 6'b001000,
    S_WRD  = 6'b010000,
    S_WWR  = 6'b100000
  } state_e;

  localparam logic [PTR_W-1:0] WORD_STEP = PTR_W'(MAP_WORD_BITS);
  localparam logic [PTR_W-1:0] MAP_END   = PTR_W'(FRAME_TOTAL);

  state_e state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CFG_W-1:0]  start_cfg_q, limit_cfg_q;
  logic [PTR_W-1:0]  s_q, s_d, p_q, p_d, end_q, end_d, cnt_q, cnt_d;
  logic              set_q, set_d;
  logic              done_q, done_d, stat_q, stat_d;
  logic [FRAME_W-1:0] grant_q, grant_d;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_addr;
  logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata;

  // search evaluation
  logic [PTR_W-1:0]         wbase, wend, seg_end, run_end, use_f, lim;
  logic [MAP_WORD_BITS-1:0] word, masked, lo_mask, hi_mask;
  logic [OFF_W-1:0]         use_idx;
  logic                     found, hit, in_map;

  bfa_ram #(
    .WIDTH(MAP_WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign cfg_ready_o     = 1'b1;
  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign granted_frame_o = grant_q;
  assign status_o        = stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_cfg_q <= '0;
      limit_cfg_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RANGE_START: start_cfg_q <= cfg_data_i;
        CFG_RANGE_LIMIT: limit_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // p_q walks the probe; for run writes it is the current word pointer
  always_comb begin
    wbase   = {p_q[PTR_W-1:OFF_W], OFF_W'(0)};
    wend    = wbase + WORD_STEP;
    in_map  = (p_q < MAP_END);
    word    = in_map ? ram_rdata : '0;
    run_end = s_q + cnt_q;
    seg_end = (run_end < wend) ? run_end : wend;
    lim     = PTR_W'(limit_cfg_q);
    masked  = word & ({MAP_WORD_BITS{1'b1}} << p_q[OFF_W-1:0]);
    found   = |masked;
    use_idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        use_idx = OFF_W'(i);
      end
    end
    use_f   = wbase + PTR_W'(use_idx);
    hit     = found && (use_f < seg_end);
    lo_mask = {MAP_WORD_BITS{1'b1}} << p_q[OFF_W-1:0];
    hi_mask = (end_q < wend) ? ~({MAP_WORD_BITS{1'b1}} << end_q[OFF_W-1:0])
                             : {MAP_WORD_BITS{1'b1}};
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    s_d       = s_q;
    p_d       = p_q;
    end_d     = end_q;
    cnt_d     = cnt_q;
    set_d     = set_q;
    done_d    = 1'b0;
    stat_d    = stat_q;
    grant_d   = grant_q;
    ram_we    = 1'b0;
    ram_addr  = p_q[OFF_W +: ADDR_W];
    ram_wdata = '0;
    case (state_q)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == ADDR_W'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          stat_d  = 1'b0;
          grant_d = '0;
          cnt_d   = PTR_W'(frame_count_i);
          case (operation_i)
            OP_ALLOC: begin
              s_d = PTR_W'(start_cfg_q);
              p_d = PTR_W'(start_cfg_q);
              if (frame_count_i == '0) begin
                grant_d = start_cfg_q[FRAME_W-1:0];
                done_d  = 1'b1;
              end else begin
                state_d = S_SRD;
              end
            end
            OP_FREE, OP_MARK: begin
              p_d     = PTR_W'(first_frame_i);
              end_d   = PTR_W'(first_frame_i) + PTR_W'(frame_count_i);
              set_d   = (operation_i == OP_MARK);
              state_d = S_WRD;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_SRD: begin
        // read issued at p_q word; frames past the map read as free
        state_d = S_SEV;
      end
      S_SEV: begin
        if ((lim < seg_end) && (!hit || (lim <= use_f))) begin
          stat_d  = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (hit) begin
          s_d     = use_f + 1'b1;
          p_d     = use_f + 1'b1;
          state_d = S_SRD;
        end else if (seg_end == run_end) begin
          grant_d = s_q[FRAME_W-1:0];
          p_d     = s_q;
          end_d   = run_end;
          set_d   = 1'b1;
          state_d = S_WRD;
        end else begin
          p_d     = wend;
          state_d = S_SRD;
        end
      end
      S_WRD: begin
        if ((p_q >= end_q) || !in_map) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_WWR;
        end
      end
      S_WWR: begin
        ram_we    = 1'b1;
        ram_wdata = set_q ? (ram_rdata | (lo_mask & hi_mask))
                          : (ram_rdata & ~(lo_mask & hi_mask));
        p_d       = wend;
        state_d   = S_WRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    p_q     <= p_d;
    end_q   <= end_d;
    cnt_q   <= cnt_d;
    set_q   <= set_d;
    stat_q  <= stat_d;
    grant_q <= grant_d;
  end

  `BFA_ASSERT(a_done_idle, !done_o || (state_q == S_IDLE), "result outside idle")
  `BFA_ASSERT(a_fail_zero, !(done_o && status_o) || (granted_frame_o == '0),
              "failed allocation with nonzero frame")
  `BFA_ASSERT(a_we_state, !ram_we || (state_q == S_CLR) || (state_q == S_WWR),
              "map write outside clear or run write")
  `BFA_ASSERT_NEXT(a_clr_busy, (state_q == S_CLR), busy_o || done_o == 1'b0,
                   "clearing pass ended with a result")

endmodule
